>>> hdl/tcc_pkg.sv
// tcc_pkg: shared types and constants of the text cursor controller
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps

package tcc_pkg;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_ABS   = 2'd1,
        CMD_REL   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_MODE    = 2'd2;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd25;
    localparam logic [1:0] MODE_RESET    = 2'd0;

    // mode flag bit positions
    localparam int MODE_WRAP     = 0;
    localparam int MODE_NOSCROLL = 1;

    // control codes
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_PRINT_MIN = 8'h10;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         char_code;
        logic signed [10:0] move_col;
        logic signed [10:0] move_row;
    } req_t;

    typedef struct packed {
        logic       glyph_write;
        logic [7:0] glyph_col;
        logic [7:0] glyph_row;
        logic [7:0] glyph_code;
        logic       scroll_up;
        logic       clear_screen;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic step;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_move;
        logic step_needed;
    } dp_status_t;

endpackage

>>> hdl/tcc_if.sv
// tcc_if: valid/ready channel interfaces of the text cursor controller
// request, response and configuration channels; no dependencies
`timescale 1ns / 1ps

interface tcc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [7:0]         char_code;
    logic signed [10:0] move_col;
    logic signed [10:0] move_row;

    modport source (output valid, command, char_code, move_col, move_row, input ready);
    modport sink   (input valid, command, char_code, move_col, move_row, output ready);
endinterface

interface tcc_rsp_if;
    logic       valid;
    logic       ready;
    logic       glyph_write;
    logic [7:0] glyph_col;
    logic [7:0] glyph_row;
    logic [7:0] glyph_code;
    logic       scroll_up;
    logic       clear_screen;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;

    modport source (output valid, glyph_write, glyph_col, glyph_row, glyph_code,
                    scroll_up, clear_screen, cursor_col, cursor_row, input ready);
    modport sink   (input valid, glyph_write, glyph_col, glyph_row, glyph_code,
                    scroll_up, clear_screen, cursor_col, cursor_row, output ready);
endinterface

interface tcc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/tcc_ctrl.sv
// tcc_ctrl: sequencing state machine of the text cursor controller
// depends on tcc_pkg; drives the datapath through ctrl_cmd_t
`timescale 1ns / 1ps

module tcc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output tcc_pkg::ctrl_cmd_t  cmd,
    input  tcc_pkg::dp_status_t stat
);
    import tcc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WRAP,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   req_ready_reg, req_ready_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && req_valid && req_ready_reg;
        cmd.exec   = (state_reg == S_EXEC);
        cmd.step   = (state_reg == S_WRAP) && stat.step_needed;
        cmd.commit = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        req_ready_next = req_ready_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    req_ready_next = 1'b0;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.is_move ? S_WRAP : S_FINISH;
            end
            S_WRAP:
            begin
                // one fold of the column count per cycle until in range
                if (!stat.step_needed)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (cmd.commit)
                begin
                    rsp_valid_next = 1'b1;
                    req_ready_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_ready_reg <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_ready_reg <= req_ready_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = req_ready_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

>>> hdl/tcc_datapath.sv
// tcc_datapath: cursor state, geometry registers and move arithmetic
// depends on tcc_pkg and tcc_cfg_if; sequenced by tcc_ctrl
`timescale 1ns / 1ps

module tcc_datapath #(
    parameter int TAB_WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    tcc_cfg_if.sink             cfg,
    input  tcc_pkg::req_t       req_data,
    output tcc_pkg::rsp_t       rsp_data,
    input  tcc_pkg::ctrl_cmd_t  cmd,
    output tcc_pkg::dp_status_t stat
);
    import tcc_pkg::*;

    // reciprocal for the next tab stop, exact for 8-bit columns
    localparam int         RECIP_SHIFT = 16;
    localparam logic [16:0] TAB_RECIP  = 17'((2 ** RECIP_SHIFT + TAB_WIDTH - 1) / TAB_WIDTH);
    localparam logic [8:0]  TAB_W9     = 9'(TAB_WIDTH);

    logic [7:0] columns_reg;
    logic [7:0] rows_reg;
    logic [1:0] mode_reg;
    logic [7:0] cur_col_reg;
    logic [7:0] cur_row_reg;

    cmd_t               in_cmd_reg;
    logic [7:0]         in_char_reg;
    logic signed [10:0] in_mcol_reg;
    logic signed [10:0] in_mrow_reg;

    logic signed [11:0] mx_reg;
    logic signed [13:0] my_reg;
    logic               gw_reg;
    logic [7:0]         gcol_reg;
    logic [7:0]         grow_reg;
    logic [7:0]         gcode_reg;
    logic               scr_reg;
    logic               clr_reg;
    rsp_t               rsp_reg;

    logic [8:0]  cols_eff, rows_eff;
    logic [24:0] tab_prod;
    logic [17:0] tab_stop_prod;
    logic [8:0]  tab_next;
    logic [8:0]  px, py;
    logic        pgw, pscr;
    logic        glyph_put;
    logic        is_move, mx_neg, mx_over;
    logic signed [11:0] mx_load;
    logic signed [13:0] my_load;
    logic [7:0]  fx, fy;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cols_eff = (columns_reg == 8'd0) ? 9'd1 : {1'b0, columns_reg};
        rows_eff = (rows_reg == 8'd0) ? 9'd1 : {1'b0, rows_reg};
    end

    // next multiple of the tab width above the cursor column
    always_comb
    begin
        tab_prod      = 25'(cur_col_reg) * 25'(TAB_RECIP);
        tab_stop_prod = 18'(tab_prod[24:RECIP_SHIFT] + 9'd1) * 18'(TAB_W9);
        tab_next      = tab_stop_prod[8:0];
    end

    // put character
    always_comb
    begin
        px   = {1'b0, cur_col_reg};
        py   = {1'b0, cur_row_reg};
        pgw  = 1'b0;
        pscr = 1'b0;
        case (in_char_reg)
            CH_NEWLINE:
            begin
                py = py + 9'd1;
                px = 9'd0;
            end
            CH_BACKSPACE:
            begin
                if (px != 9'd0)
                    px = px - 9'd1;
                else if (py != 9'd0)
                begin
                    py = py - 9'd1;
                    px = cols_eff - 9'd1;
                end
            end
            CH_RETURN:
            begin
                px = 9'd0;
            end
            CH_TAB:
            begin
                px = tab_next;
                if (px >= cols_eff)
                begin
                    px = px - cols_eff;
                    py = py + 9'd1;
                end
            end
            default:
            begin
                if (in_char_reg inside {[CH_PRINT_MIN:8'hFF]})
                begin
                    pgw = 1'b1;
                    if (px + 9'd1 == cols_eff)
                    begin
                        px = 9'd0;
                        py = py + 9'd1;
                    end
                    else
                        px = px + 9'd1;
                end
            end
        endcase
        // bottom reached: scroll one row at most
        if (py >= rows_eff)
        begin
            pscr = !mode_reg[MODE_NOSCROLL];
            py   = py - 9'd1;
            px   = 9'd0;
        end
        if (px > 9'd255)
            px = 9'd255;
        if (py > 9'd255)
            py = 9'd255;
    end

    assign glyph_put = (in_cmd_reg == CMD_PUT) && pgw;

    // move targets, relative ones offset by the cursor
    always_comb
    begin
        mx_load = 12'(in_mcol_reg);
        my_load = 14'(in_mrow_reg);
        if (in_cmd_reg == CMD_REL)
        begin
            mx_load = mx_load + $signed({4'b0, cur_col_reg});
            my_load = my_load + $signed({6'b0, cur_row_reg});
        end
    end

    always_comb
    begin
        is_move          = (in_cmd_reg == CMD_ABS) || (in_cmd_reg == CMD_REL);
        mx_neg           = mx_reg[11];
        mx_over          = !mx_neg && (mx_reg >= $signed({3'b0, cols_eff}));
        stat.is_move     = is_move;
        stat.step_needed = is_move && mode_reg[MODE_WRAP] && (mx_neg || mx_over);
    end

    // final cursor: moves clamp to the screen
    always_comb
    begin
        fx = mx_reg[7:0];
        fy = my_reg[7:0];
        if (is_move)
        begin
            if (mx_neg)
                fx = 8'd0;
            else if (mx_over)
                fx = 8'(cols_eff - 9'd1);
            if (my_reg[13])
                fy = 8'd0;
            else if (my_reg >= $signed({5'b0, rows_eff}))
                fy = 8'(rows_eff - 9'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
            mode_reg    <= MODE_RESET;
            cur_col_reg <= 8'd0;
            cur_row_reg <= 8'd0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_COLUMNS: columns_reg <= cfg.data;
                    REG_ROWS:    rows_reg    <= cfg.data;
                    REG_MODE:    mode_reg    <= cfg.data[1:0];
                    default:     ;
                endcase
            end
            if (cmd.commit)
            begin
                cur_col_reg <= fx;
                cur_row_reg <= fy;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_cmd_reg  <= cmd_t'(req_data.command);
            in_char_reg <= req_data.char_code;
            in_mcol_reg <= req_data.move_col;
            in_mrow_reg <= req_data.move_row;
        end
        if (cmd.exec)
        begin
            gw_reg    <= glyph_put;
            gcol_reg  <= glyph_put ? cur_col_reg : 8'd0;
            grow_reg  <= glyph_put ? cur_row_reg : 8'd0;
            gcode_reg <= glyph_put ? in_char_reg : 8'd0;
            scr_reg   <= (in_cmd_reg == CMD_PUT) && pscr;
            clr_reg   <= (in_cmd_reg == CMD_CLEAR);
            case (in_cmd_reg)
                CMD_PUT:
                begin
                    mx_reg <= $signed({3'b0, px});
                    my_reg <= $signed({5'b0, py});
                end
                CMD_CLEAR:
                begin
                    mx_reg <= 12'sd0;
                    my_reg <= 14'sd0;
                end
                default:
                begin
                    mx_reg <= mx_load;
                    my_reg <= my_load;
                end
            endcase
        end
        if (cmd.step)
        begin
            if (mx_neg)
            begin
                mx_reg <= mx_reg + $signed({3'b0, cols_eff});
                my_reg <= my_reg - 14'sd1;
            end
            else
            begin
                mx_reg <= mx_reg - $signed({3'b0, cols_eff});
                my_reg <= my_reg + 14'sd1;
            end
        end
        if (cmd.commit)
        begin
            rsp_reg.glyph_write  <= gw_reg;
            rsp_reg.glyph_col    <= gcol_reg;
            rsp_reg.glyph_row    <= grow_reg;
            rsp_reg.glyph_code   <= gcode_reg;
            rsp_reg.scroll_up    <= scr_reg;
            rsp_reg.clear_screen <= clr_reg;
            rsp_reg.cursor_col   <= fx;
            rsp_reg.cursor_row   <= fy;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

>>> hdl/text_cursor_controller.sv
// text_cursor_controller: cursor tracking for a text-mode screen
// put character and clear pass through the exec and finish states, the finish state holding until
// any earlier result is taken; moves also pass the wrap state, folding the column one step per cycle until in range
// one item at a time: a new request is taken only once the last result is committed
// reset: cursor at 0,0, columns 80, rows 25, mode flags 0; no item or result pending
`timescale 1ns / 1ps

module text_cursor_controller #(
    parameter int TAB_WIDTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    tcc_cfg_if.sink    cfg,
    tcc_req_if.sink    req,
    tcc_rsp_if.source  rsp
);
    import tcc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;
    req_t       req_data;
    rsp_t       rsp_data;

    assign req_data.command   = req.command;
    assign req_data.char_code = req.char_code;
    assign req_data.move_col  = req.move_col;
    assign req_data.move_row  = req.move_row;

    assign rsp.glyph_write  = rsp_data.glyph_write;
    assign rsp.glyph_col    = rsp_data.glyph_col;
    assign rsp.glyph_row    = rsp_data.glyph_row;
    assign rsp.glyph_code   = rsp_data.glyph_code;
    assign rsp.scroll_up    = rsp_data.scroll_up;
    assign rsp.clear_screen = rsp_data.clear_screen;
    assign rsp.cursor_col   = rsp_data.cursor_col;
    assign rsp.cursor_row   = rsp_data.cursor_row;

    tcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    tcc_datapath #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req_data (req_data),
        .rsp_data (rsp_data),
        .cmd      (cmd),
        .stat     (stat)
    );

`ifndef SYNTHESIS
    // one item in flight: no second transfer right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while an item is in flight");

    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.clear_screen |->
            (rsp.cursor_col == 8'd0) && (rsp.cursor_row == 8'd0) && !rsp.glyph_write)
        else $error("clear result does not home the cursor");

    a_no_glyph_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.glyph_write |->
            (rsp.glyph_code == 8'd0) && (rsp.glyph_col == 8'd0) && (rsp.glyph_row == 8'd0))
        else $error("glyph fields set without a glyph write");
`endif

endmodule
